// File: hw/rtl/hdmp_pkg.sv
// ============================================================================
// hdmp_pkg - shared types and constants for the hex dash message parser
// Line state, result record, phase codes and character constants.
// ============================================================================
package hdmp_pkg;

  // Field phase: what has been seen of the field being read
  typedef enum logic [1:0] {
    PH_EMPTY  = 2'd0,   // nothing yet
    PH_ZERO   = 2'd1,   // a lone leading zero, prefix may follow
    PH_PREFIX = 2'd2,   // "0x" seen, no digits yet
    PH_DIGITS = 2'd3    // at least one digit counted
  } phase_t;

  // Parser state carried from character to character
  typedef struct packed {
    logic [2:0]  fields_done;
    phase_t      phase;
    logic [10:0] acc;
    logic [10:0] sender;
    logic [7:0]  addressee;
    logic [7:0]  command;
    logic        err;
    logic        last_dash;
  } line_state_t;

  // One parse result
  typedef struct packed {
    logic        line_valid;
    logic [10:0] sender_id;
    logic [7:0]  addressee;
    logic [7:0]  command_code;
    logic [7:0]  payload_byte;
  } result_t;

  localparam line_state_t LINE_CLEAR       = '0;
  localparam logic [2:0]  FIELD_COUNT      = 3'd4;
  localparam logic [10:0] BYTE_MAX         = 11'h0FF;
  localparam logic [10:0] SENDER_MAX_RESET = 11'd2047;

  localparam logic [7:0] CHAR_DASH    = 8'h2D;  // '-'
  localparam logic [7:0] CHAR_X_LOWER = 8'h78;  // 'x'
  localparam logic [7:0] CHAR_X_UPPER = 8'h58;  // 'X'
  localparam logic [7:0] CHAR_0       = 8'h30;
  localparam logic [7:0] CHAR_9       = 8'h39;
  localparam logic [7:0] CHAR_A_LOWER = 8'h61;
  localparam logic [7:0] CHAR_F_LOWER = 8'h66;
  localparam logic [7:0] CHAR_A_UPPER = 8'h41;
  localparam logic [7:0] CHAR_F_UPPER = 8'h46;

  // Hex digit decode: bit 4 flags a digit, bits 3:0 hold its value
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [7:0] v;
    begin
      v = 8'd0;
      hex_digit = 5'd0;
      if (c >= CHAR_0 && c <= CHAR_9) begin
        v = c - CHAR_0;
        hex_digit = {1'b1, v[3:0]};
      end else if (c >= CHAR_A_LOWER && c <= CHAR_F_LOWER) begin
        v = c - CHAR_A_LOWER + 8'd10;
        hex_digit = {1'b1, v[3:0]};
      end else if (c >= CHAR_A_UPPER && c <= CHAR_F_UPPER) begin
        v = c - CHAR_A_UPPER + 8'd10;
        hex_digit = {1'b1, v[3:0]};
      end
    end
  endfunction

endpackage

// File: hw/rtl/hdmp_core.sv
// ============================================================================
// hdmp_core - next-state logic of the line parser
// Takes the current line state and one transaction, gives the next state
// and, on end of line, the parse result.
// ============================================================================
module hdmp_core (
  input  hdmp_pkg::line_state_t cur,
  input  logic [7:0]            character,
  input  logic                  end_of_line,
  input  logic [10:0]           max_sender_id,
  output hdmp_pkg::line_state_t nxt,
  output hdmp_pkg::result_t     res
);

  // Close the field being read; error on empty field, bare prefix or a fifth
  function automatic hdmp_pkg::line_state_t finish_field(input hdmp_pkg::line_state_t s);
    hdmp_pkg::line_state_t t;
    begin
      t = s;
      if (s.phase == hdmp_pkg::PH_EMPTY || s.phase == hdmp_pkg::PH_PREFIX ||
          s.fields_done >= hdmp_pkg::FIELD_COUNT) begin
        t.err = 1'b1;
      end else begin
        case (s.fields_done)
          3'd0:    t.sender    = s.acc;
          3'd1:    t.addressee = s.acc[7:0];
          3'd2:    t.command   = s.acc[7:0];
          default: ;
        endcase
        t.fields_done = s.fields_done + 3'd1;
        if (t.fields_done < hdmp_pkg::FIELD_COUNT) begin
          t.acc   = 11'd0;
          t.phase = hdmp_pkg::PH_EMPTY;
        end
      end
      finish_field = t;
    end
  endfunction

  hdmp_pkg::line_state_t fin;
  logic [4:0]            dig;
  logic [10:0]           limit;
  logic [14:0]           acc_next;
  logic                  ok;

  // Digit decode, shift-add and range limit
  assign dig      = hdmp_pkg::hex_digit(character);
  assign limit    = (cur.fields_done == 3'd0) ? max_sender_id : hdmp_pkg::BYTE_MAX;
  assign acc_next = {cur.acc, 4'b0000} + {11'd0, dig[3:0]};

  // End of line: close the last field unless a trailing dash already did
  always_comb begin
    fin = cur;
    if (!cur.err && !cur.last_dash) begin
      fin = finish_field(cur);
    end
    ok = !fin.err && (fin.fields_done == hdmp_pkg::FIELD_COUNT);
    res.line_valid   = ok;
    res.sender_id    = ok ? fin.sender    : 11'd0;
    res.addressee    = ok ? fin.addressee : 8'd0;
    res.command_code = ok ? fin.command   : 8'd0;
    res.payload_byte = ok ? fin.acc[7:0]  : 8'd0;
  end

  // Character update
  always_comb begin
    nxt = cur;
    if (end_of_line) begin
      nxt = hdmp_pkg::LINE_CLEAR;
    end else if (cur.err) begin
      nxt = cur;
    end else if (cur.fields_done >= hdmp_pkg::FIELD_COUNT) begin
      nxt.err = 1'b1;
    end else if (character == hdmp_pkg::CHAR_DASH) begin
      nxt           = finish_field(cur);
      nxt.last_dash = 1'b1;
    end else begin
      nxt.last_dash = 1'b0;
      if (cur.phase == hdmp_pkg::PH_ZERO &&
          (character == hdmp_pkg::CHAR_X_LOWER || character == hdmp_pkg::CHAR_X_UPPER)) begin
        nxt.phase = hdmp_pkg::PH_PREFIX;
      end else if (!dig[4]) begin
        nxt.err = 1'b1;
      end else if (acc_next > {4'd0, limit}) begin
        nxt.err = 1'b1;
      end else begin
        nxt.acc = acc_next[10:0];
        if (cur.phase == hdmp_pkg::PH_EMPTY && dig[3:0] == 4'd0) begin
          nxt.phase = hdmp_pkg::PH_ZERO;
        end else begin
          nxt.phase = hdmp_pkg::PH_DIGITS;
        end
      end
    end
  end

endmodule

// File: hw/rtl/hex_dash_message_parser.sv
// ============================================================================
// hex_dash_message_parser - four-field hex line parser
// Parses "a-b-c-d" hex lines one character per transaction and returns one
// result per end-of-line transaction.
// ============================================================================
//
//  channel  direction  handshake          payload
//  in_      input      in_valid/in_stall  in_character, in_end_of_line
//  out_     output     out_valid/out_stall out_line_valid, out_sender_id,
//                                         out_addressee, out_command_code,
//                                         out_payload_byte
//  cfg_     input      cfg_valid/cfg_ready cfg_max_sender_id
//
//  One transaction per cycle while in_stall is low. A transaction is held in
//  the input register, then the parser updates the line state; an end-of-line
//  result is then registered in the output register.
//  An end-of-line transaction waits in the input register only while the
//  output register is full and stalled; characters never wait.
//  rst_n is synchronous: line state cleared, max_sender_id back to 2047.
//
module hex_dash_message_parser (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_character,
  input  logic        in_end_of_line,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_line_valid,
  output logic [10:0] out_sender_id,
  output logic [7:0]  out_addressee,
  output logic [7:0]  out_command_code,
  output logic [7:0]  out_payload_byte,
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [10:0] cfg_max_sender_id
);

  logic                  s1_valid_r, s1_valid_nxt;
  logic [7:0]            s1_char_r;
  logic                  s1_eol_r;
  logic                  s1_go;
  logic                  in_take;
  logic                  out_free;
  logic [10:0]           max_sender_r;
  hdmp_pkg::line_state_t st_r, st_nxt;
  hdmp_pkg::result_t     res_r, res_nxt;
  logic                  out_valid_r, out_valid_nxt;

  // Handshake control
  assign out_free     = !out_valid_r || !out_stall;
  assign s1_go        = s1_valid_r && (!s1_eol_r || out_free);
  assign in_stall     = s1_valid_r && !s1_go;
  assign in_take      = in_valid && !in_stall;
  assign s1_valid_nxt = in_take || (s1_valid_r && !s1_go);
  assign out_valid_nxt = (s1_go && s1_eol_r) || (out_valid_r && out_stall);
  assign cfg_ready    = 1'b1;

  hdmp_core u_core (
    .cur           (st_r),
    .character     (s1_char_r),
    .end_of_line   (s1_eol_r),
    .max_sender_id (max_sender_r),
    .nxt           (st_nxt),
    .res           (res_nxt)
  );

  // Control registers and line state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      st_r         <= hdmp_pkg::LINE_CLEAR;
      max_sender_r <= hdmp_pkg::SENDER_MAX_RESET;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (s1_go) begin
        st_r <= st_nxt;
      end
      if (cfg_valid && cfg_ready) begin
        max_sender_r <= cfg_max_sender_id;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_char_r <= in_character;
      s1_eol_r  <= in_end_of_line;
    end
    if (s1_go && s1_eol_r) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_line_valid   = res_r.line_valid;
  assign out_sender_id    = res_r.sender_id;
  assign out_addressee    = res_r.addressee;
  assign out_command_code = res_r.command_code;
  assign out_payload_byte = res_r.payload_byte;

`ifndef SYNTH
  // A new result only follows an end-of-line transaction
  a_result_from_eol: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid_r || !out_stall) && out_valid_nxt |-> s1_valid_r && s1_eol_r)
    else $error("result without end of line");

  // Line state is clear after each end of line
  a_clear_after_eol: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go && s1_eol_r |=> st_r == hdmp_pkg::LINE_CLEAR)
    else $error("line state not cleared after end of line");

  // An invalid line reports all fields zero
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !res_r.line_valid |->
      res_r.sender_id == 11'd0 && res_r.addressee == 8'd0 &&
      res_r.command_code == 8'd0 && res_r.payload_byte == 8'd0)
    else $error("invalid line with non-zero fields");

  // Byte fields never exceed 255 in the accumulator
  a_byte_range: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.fields_done != 3'd0 |-> st_r.acc <= hdmp_pkg::BYTE_MAX)
    else $error("byte field out of range");

  // A stalled input means the input register is occupied
  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && s1_eol_r && out_valid_r)
    else $error("input stalled with nothing waiting");
`endif

endmodule
